[hdl/isr_pkg.sv]
// ----------------------------------------------------------------------------
// isr_pkg
// shared types and constants for the integer square root unit
// ----------------------------------------------------------------------------
package isr_pkg;

    localparam int OPND_W    = 64;
    localparam int ROOT_W    = 32;
    localparam int REM_W     = ROOT_W + 2;
    localparam int TRIAL_W   = REM_W + 2;
    localparam int FRAC_BITS = 16;
    localparam int LOW_W     = 32;
    localparam int KIND_W    = 2;
    localparam int CNT_W     = $clog2(ROOT_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(ROOT_W - 1);

    typedef enum logic [KIND_W-1:0] {
        KIND_INT32 = 2'd0,
        KIND_INT64 = 2'd1,
        KIND_FIX16 = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic push;
    } t_cmd;

endpackage

[hdl/isr_dp.sv]
// ----------------------------------------------------------------------------
// isr_dp
// operand shifter, remainder and partial root registers, output register
// ----------------------------------------------------------------------------
module isr_dp (
    input  logic                            i_clk,
    input  isr_pkg::t_cmd                   i_cmd,
    input  logic [isr_pkg::KIND_W-1:0]      i_kind,
    input  logic [isr_pkg::OPND_W-1:0]      i_value,
    output logic [isr_pkg::ROOT_W-1:0]      o_root
);

    logic [isr_pkg::OPND_W-1:0]  r_opnd, n_opnd;
    logic [isr_pkg::REM_W-1:0]   r_rem,  n_rem;
    logic [isr_pkg::ROOT_W-1:0]  r_root, n_root;
    logic [isr_pkg::ROOT_W-1:0]  r_out;
    logic [isr_pkg::OPND_W-1:0]  sel_opnd;
    logic [isr_pkg::TRIAL_W-1:0] rem_sh;
    logic [isr_pkg::TRIAL_W-1:0] trial;
    logic [isr_pkg::TRIAL_W-1:0] diff;
    logic                        fits;
    isr_pkg::t_kind              kind;

    assign kind = isr_pkg::t_kind'(i_kind);

    always_comb begin
        unique case (kind)
            isr_pkg::KIND_INT32: sel_opnd = {{(isr_pkg::OPND_W - isr_pkg::LOW_W){1'b0}},
                                             i_value[isr_pkg::LOW_W-1:0]};
            isr_pkg::KIND_INT64: sel_opnd = i_value;
            isr_pkg::KIND_FIX16: sel_opnd = {{(isr_pkg::OPND_W - isr_pkg::LOW_W
                                               - isr_pkg::FRAC_BITS){1'b0}},
                                             i_value[isr_pkg::LOW_W-1:0],
                                             {isr_pkg::FRAC_BITS{1'b0}}};
            default:             sel_opnd = '0;
        endcase
    end

    // one root bit per step
    assign rem_sh = {r_rem, r_opnd[isr_pkg::OPND_W-1 -: 2]};
    assign trial  = {{(isr_pkg::TRIAL_W - isr_pkg::ROOT_W - 2){1'b0}}, r_root, 2'b01};
    assign diff   = rem_sh - trial;
    assign fits   = rem_sh >= trial;

    always_comb begin
        n_opnd = r_opnd;
        n_rem  = r_rem;
        n_root = r_root;
        priority if (i_cmd.load) begin
            n_opnd = sel_opnd;
            n_rem  = '0;
            n_root = '0;
        end else if (i_cmd.step) begin
            n_opnd = {r_opnd[isr_pkg::OPND_W-3:0], 2'b00};
            n_rem  = fits ? diff[isr_pkg::REM_W-1:0] : rem_sh[isr_pkg::REM_W-1:0];
            n_root = {r_root[isr_pkg::ROOT_W-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        r_opnd <= n_opnd;
        r_rem  <= n_rem;
        r_root <= n_root;
        if (i_cmd.push) begin
            r_out <= r_root;
        end
    end

    assign o_root = r_out;

endmodule

[hdl/isr_ctrl.sv]
// ----------------------------------------------------------------------------
// isr_ctrl
// sequencer for the digit-by-digit root and the output handshake
// ----------------------------------------------------------------------------
module isr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output isr_pkg::t_cmd o_cmd
);

    isr_pkg::t_state             r_state, n_state;
    logic [isr_pkg::CNT_W-1:0]   r_cnt,   n_cnt;
    logic                        r_out_valid, n_out_valid;
    logic                        out_free;
    logic                        in_ready;
    logic                        accept;

    assign out_free = !r_out_valid || !i_out_stall;
    assign in_ready = (r_state == isr_pkg::S_IDLE) ||
                      ((r_state == isr_pkg::S_DONE) && out_free);
    assign accept   = i_in_valid && in_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            isr_pkg::S_IDLE: begin
                if (accept) n_state = isr_pkg::S_RUN;
            end
            isr_pkg::S_RUN: begin
                if (r_cnt == isr_pkg::LAST_STEP) n_state = isr_pkg::S_DONE;
            end
            isr_pkg::S_DONE: begin
                if (out_free) n_state = accept ? isr_pkg::S_RUN : isr_pkg::S_IDLE;
            end
            default: n_state = isr_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.load = accept;
        unique case (r_state)
            isr_pkg::S_IDLE: ;
            isr_pkg::S_RUN:  o_cmd.step = 1'b1;
            isr_pkg::S_DONE: o_cmd.push = out_free;
            default: ;
        endcase
    end

    always_comb begin
        n_cnt = r_cnt;
        if (accept) begin
            n_cnt = '0;
        end else if (r_state == isr_pkg::S_RUN) begin
            n_cnt = r_cnt + 1'b1;
        end
        n_out_valid = r_out_valid;
        if (o_cmd.push) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= isr_pkg::S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = !in_ready;
    assign o_out_valid = r_out_valid;

`ifndef ASSERT_OFF
    a_accept_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == isr_pkg::S_RUN) && (r_cnt == '0))
        else $error("request accepted without starting a run");

    a_cnt_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == isr_pkg::S_RUN) && (r_cnt != isr_pkg::LAST_STEP)
        |=> (r_state == isr_pkg::S_RUN) && (r_cnt == $past(r_cnt) + 1'b1))
        else $error("step counter out of sequence");

    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.push |=> r_out_valid)
        else $error("pushed root not presented");

    a_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == isr_pkg::S_DONE) && !out_free |=> (r_state == isr_pkg::S_DONE))
        else $error("finished root dropped while output busy");
`endif

endmodule

[hdl/integer_square_root.sv]
// ----------------------------------------------------------------------------
// integer_square_root
// floor square root of a 32-bit, 64-bit or 16.16 fixed-point operand
// ----------------------------------------------------------------------------
//  channel  direction  handshake                  payload
//  in       to block   i_in_valid / o_in_stall    i_kind, i_value
//  out      from block o_out_valid / i_out_stall  o_root
//
//  one request takes a load and 32 steps of the shared
//  compare-and-subtract unit, one root bit per step, in every mode
//  the root then sits in an output register; the next request is taken
//  as soon as the root has moved there, while it waits to be taken
//  a stalled output holds the finished root in the unit and stalls input
//  synchronous active-low reset clears the sequencer and output valid
module integer_square_root (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [isr_pkg::KIND_W-1:0]    i_kind,
    input  logic [isr_pkg::OPND_W-1:0]    i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [isr_pkg::ROOT_W-1:0]    o_root
);

    isr_pkg::t_cmd cmd;

    isr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    isr_dp u_dp (
        .i_clk   (i_clk),
        .i_cmd   (cmd),
        .i_kind  (i_kind),
        .i_value (i_value),
        .o_root  (o_root)
    );

endmodule

[bench/isr_checker.sv]
// ----------------------------------------------------------------------------
// isr_checker
// watches both channels of the integer square root unit, works out the
// floor root of every accepted request and compares it with each root that
// leaves the unit, oldest first; counts mismatches and open requests
// ----------------------------------------------------------------------------
module isr_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  logic [isr_pkg::KIND_W-1:0]   i_kind,
    input  logic [isr_pkg::OPND_W-1:0]   i_value,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic [isr_pkg::ROOT_W-1:0]   i_root,
    output int                           o_fail_count,
    output int                           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [isr_pkg::ROOT_W-1:0] root_queue[$];
    int                         fail_count = 0;

    function automatic logic [isr_pkg::ROOT_W-1:0] floor_root(
        input logic [isr_pkg::OPND_W-1:0] opnd);
        logic [isr_pkg::OPND_W-1:0] rest;
        logic [isr_pkg::OPND_W-1:0] acc;
        logic [isr_pkg::OPND_W-1:0] digit;
        rest = opnd;
        acc  = '0;
        for (int i = isr_pkg::ROOT_W - 1; i >= 0; i--) begin
            digit = 64'd1 << (2 * i);
            if (rest >= acc + digit) begin
                rest = rest - (acc + digit);
                acc  = (acc >> 1) + digit;
            end else begin
                acc = acc >> 1;
            end
        end
        return acc[isr_pkg::ROOT_W-1:0];
    endfunction

    function automatic logic [isr_pkg::ROOT_W-1:0] predict_root(
        input isr_pkg::t_kind kind, input logic [isr_pkg::OPND_W-1:0] value);
        logic [isr_pkg::LOW_W-1:0] low;
        low = value[isr_pkg::LOW_W-1:0];
        case (kind)
            isr_pkg::KIND_INT32:
                return floor_root({{(isr_pkg::OPND_W - isr_pkg::LOW_W){1'b0}}, low});
            isr_pkg::KIND_INT64:
                return floor_root(value);
            isr_pkg::KIND_FIX16:
                return floor_root({{(isr_pkg::OPND_W - isr_pkg::LOW_W
                                     - isr_pkg::FRAC_BITS){1'b0}},
                                   low, {isr_pkg::FRAC_BITS{1'b0}}});
            default:
                return '0;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        fail_count++;
    endtask

    always @(posedge i_clk) begin : monitor
        logic [isr_pkg::ROOT_W-1:0] want;
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                if (root_queue.size() == 0) begin
                    report_mismatch($sformatf("root %h with no request open", i_root));
                end else begin
                    want = root_queue.pop_front();
                    if (i_root !== want)
                        report_mismatch($sformatf("root %h, expected %h", i_root, want));
                end
            end
            if (i_in_valid && !i_in_stall)
                root_queue.push_back(predict_root(isr_pkg::t_kind'(i_kind), i_value));
        end
        o_pending    <= root_queue.size();
        o_fail_count <= fail_count;
    end

endmodule

[bench/tb_integer_square_root.sv]
// ----------------------------------------------------------------------------
// tb_integer_square_root
// drives directed and random requests in all modes into the square root
// unit with random gaps and output stalls, including one long output
// hold-off; the checker beside the unit predicts and compares every root
// ----------------------------------------------------------------------------
module tb_integer_square_root;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_RANDOM  = 1730;
    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 400;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic [isr_pkg::KIND_W-1:0] in_kind;
    logic [isr_pkg::OPND_W-1:0] in_value;
    logic                       out_valid;
    logic                       out_stall;
    logic [isr_pkg::ROOT_W-1:0] out_root;
    int                         fail_count;
    int                         pending;
    int                         idle_cycles = 0;
    bit                         quiet_in = 1'b0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    integer_square_root uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_kind      (in_kind),
        .i_value     (in_value),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_root      (out_root)
    );

    isr_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_kind       (in_kind),
        .i_value      (in_value),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_root       (out_root),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no request moved for %0d cycles", IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_request(input isr_pkg::t_kind kind,
                                input logic [isr_pkg::OPND_W-1:0] value);
        int gap;
        gap = quiet_in ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_kind  <= kind;
        in_value <= value;
        do @(posedge clk); while (in_stall);
    endtask

    initial begin : stimulus
        logic [isr_pkg::OPND_W-1:0] value;
        logic [isr_pkg::OPND_W-1:0] r;
        isr_pkg::t_kind             kind;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_kind  <= isr_pkg::KIND_INT32;
        in_value <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(isr_pkg::KIND_INT32, 64'd0);
        send_request(isr_pkg::KIND_INT32, 64'd1);
        send_request(isr_pkg::KIND_INT64, 64'd0);
        send_request(isr_pkg::KIND_INT64, 64'd1);
        send_request(isr_pkg::KIND_FIX16, 64'd0);
        send_request(isr_pkg::KIND_FIX16, 64'd1);
        send_request(isr_pkg::KIND_INT32, 64'd3);
        send_request(isr_pkg::KIND_INT32, 64'd4);
        send_request(isr_pkg::KIND_INT32, 64'h0000_0000_FFFF_FFFF);
        send_request(isr_pkg::KIND_INT32, 64'hFFFF_FFFF_0000_0004);
        send_request(isr_pkg::KIND_INT32, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(isr_pkg::KIND_INT64, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(isr_pkg::KIND_INT64, 64'hFFFF_FFFE_0000_0001);
        send_request(isr_pkg::KIND_INT64, 64'hFFFF_FFFE_0000_0000);
        send_request(isr_pkg::KIND_INT64, 64'h8000_0000_0000_0000);
        send_request(isr_pkg::KIND_INT64, 64'h0000_0001_0000_0000);
        send_request(isr_pkg::KIND_FIX16, 64'h0000_0000_FFFF_FFFF);
        send_request(isr_pkg::KIND_FIX16, 64'hFFFF_FFFF_0001_0000);
        send_request(isr_pkg::KIND_FIX16, 64'h0000_0000_0004_0000);
        send_request(isr_pkg::KIND_NONE,  64'd0);
        send_request(isr_pkg::KIND_NONE,  64'hFFFF_FFFF_FFFF_FFFF);
        send_request(isr_pkg::KIND_NONE,  64'h1234_5678_9ABC_DEF0);

        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n % 64 == 0)
                quiet_in = ($urandom_range(0, 3) == 0);
            kind = isr_pkg::t_kind'($urandom_range(0, 9) / 3);
            case ($urandom_range(0, 4))
                0: value = {$urandom, $urandom};
                1: value = {$urandom, 32'($urandom_range(0, 300))};
                2: begin
                    r = (kind == isr_pkg::KIND_INT64) ? 64'($urandom)
                                                      : 64'($urandom_range(0, 65535));
                    value = r * r + 64'($urandom_range(0, 2)) - 64'd1;
                    value[63:32] = (kind == isr_pkg::KIND_INT64) ? value[63:32] : $urandom;
                end
                3: value = {$urandom, $urandom} >> $urandom_range(0, 63);
                default: value = {$urandom, 32'hFFFF_FFFF} >> (32 * $urandom_range(0, 1));
            endcase
            send_request(kind, value);
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin : drain
        int gap;
        int taken;
        bit quiet_out;
        out_stall <= 1'b0;
        taken     = 0;
        quiet_out = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (taken % 50 == 0)
                quiet_out = ($urandom_range(0, 3) == 0);
            gap = quiet_out ? 0 : $urandom_range(0, 14);
            // long hold-off so the unit fills and stalls its input
            if (taken == 300)
                gap = HOLD_CYCLES;
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid);
            taken++;
        end
    end

endmodule
